// ===== hw/rtl/uia2_pkg.sv =====
// shared types, constants and GF(2^64) helpers for the uia2 mac block
// no dependencies

package uia2_pkg;

    localparam int unsigned GF_W      = 64;
    localparam int unsigned LEN_W     = 32;
    localparam int unsigned MAC_W     = 32;
    localparam int unsigned DIGIT_W   = 4;
    localparam int unsigned DIGITS    = GF_W / DIGIT_W;
    localparam int unsigned DCNT_W    = $clog2(DIGITS);
    localparam int unsigned S_DATA_W  = 96;
    localparam int unsigned M_DATA_W  = 32;
    localparam int unsigned CFG_IDX_W = 2;
    localparam int unsigned CFG_DAT_W = 64;
    localparam int unsigned REM_W     = 6;

    localparam logic [GF_W-1:0] GF64_REDUCE = 64'h0000_0000_0000_001b;

    localparam logic [CFG_IDX_W-1:0] CFG_KEY_P = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_Q = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MASK  = 2'd2;

    typedef struct packed {
        logic            go;
        logic [GF_W-1:0] opa;
        logic [GF_W-1:0] opb;
    } t_mul_ctl;

    typedef struct packed {
        logic            busy;
        logic            done;
        logic [GF_W-1:0] product;
    } t_mul_stat;

    function automatic logic [GF_W-1:0] gf64_times_x(input logic [GF_W-1:0] v);
        gf64_times_x = {v[GF_W-2:0], 1'b0} ^ (v[GF_W-1] ? GF64_REDUCE : '0);
    endfunction

    function automatic logic [GF_W-1:0] gf64_times_x4(input logic [GF_W-1:0] v);
        logic [GF_W-1:0] t;
        t = v;
        for (int i = 0; i < DIGIT_W; i++) begin
            t = gf64_times_x(t);
        end
        gf64_times_x4 = t;
    endfunction

    function automatic logic [GF_W-1:0] gf64_times_digit(input logic [GF_W-1:0] v,
                                                          input logic [DIGIT_W-1:0] d);
        logic [GF_W-1:0] t;
        logic [GF_W-1:0] s;
        t = v;
        s = '0;
        for (int i = 0; i < DIGIT_W; i++) begin
            if (d[i]) begin
                s = s ^ t;
            end
            t = gf64_times_x(t);
        end
        gf64_times_digit = s;
    endfunction

endpackage

// ===== hw/rtl/uia2_gf64_polynomial_mac_core.sv =====
// uia2 f9 polynomial hash and masked mac output stage
// depends on uia2_pkg and uia2_gf_mul
//
// channel   | direction | payload (low bit up)                       | transaction
// s stream  | in        | tdata: message_block, message_length; tlast | tvalid & tready
// m stream  | out       | tdata: mac_value                            | tvalid & tready
// cfg write | in        | index, data (0 key p, 1 key q, 2 mask)      | wr_en
//
// a non-final block takes one gf multiply from transaction to next ready (one key digit per
// cycle in the shared multiplier) plus load and write-back
// a final block takes two multiplies from transaction to next ready,
// plus any wait for the output register
// synchronous active-low reset clears accumulator, keys and mask
// a stalled output holds the block in its emit state until the mac register frees

module uia2_gf64_polynomial_mac_core (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_s_tvalid,
    output logic                               o_s_tready,
    input  logic [uia2_pkg::S_DATA_W-1:0]      i_s_tdata,  // message_block, message_length
    input  logic                               i_s_tlast,  // final_block
    output logic                               o_m_tvalid,
    input  logic                               i_m_tready,
    output logic [uia2_pkg::M_DATA_W-1:0]      o_m_tdata,  // mac_value
    input  logic                               i_cfg_wr_en,
    input  logic [uia2_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [uia2_pkg::CFG_DAT_W-1:0]     i_cfg_data
);
    import uia2_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MUL_P,
        ST_MUL_Q,
        ST_EMIT
    } t_state;

    t_state            r_state;
    logic [GF_W-1:0]   r_key_p;
    logic [GF_W-1:0]   r_key_q;
    logic [MAC_W-1:0]  r_mask;
    logic [GF_W-1:0]   r_acc;
    logic              r_last;
    logic [LEN_W-1:0]  r_len;
    logic [GF_W-1:0]   r_hash;
    logic              r_out_valid;
    logic [MAC_W-1:0]  r_out_data;
    t_mul_ctl          r_mul_ctl;
    t_mul_stat         mul_stat;

    logic              s_fire;
    logic [GF_W-1:0]   in_block;
    logic [LEN_W-1:0]  in_len;
    logic [REM_W-1:0]  in_rem;
    logic [GF_W-1:0]   keep_mask;
    logic              out_free;

    assign s_fire   = i_s_tvalid && o_s_tready;
    assign in_block = i_s_tdata[GF_W-1:0];
    assign in_len   = i_s_tdata[GF_W +: LEN_W];
    assign in_rem   = in_len[REM_W-1:0];
    assign out_free = !r_out_valid || i_m_tready;

    // keep the first rem bits of the final block
    always_comb begin
        if (i_s_tlast && in_rem != '0) begin
            keep_mask = ~({GF_W{1'b1}} >> in_rem);
        end else begin
            keep_mask = {GF_W{1'b1}};
        end
    end

    uia2_gf_mul u_mul (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_ctl  (r_mul_ctl),
        .o_stat (mul_stat)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_p <= '0;
            r_key_q <= '0;
            r_mask  <= '0;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                CFG_KEY_P: r_key_p <= i_cfg_data;
                CFG_KEY_Q: r_key_q <= i_cfg_data;
                CFG_MASK:  r_mask  <= i_cfg_data[MAC_W-1:0];
                default:   ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_IDLE;
            r_acc         <= '0;
            r_out_valid   <= 1'b0;
            r_mul_ctl.go  <= 1'b0;
            r_last        <= 1'b0;
        end else begin
            r_mul_ctl.go <= 1'b0;
            if (r_out_valid && i_m_tready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (s_fire) begin
                        r_mul_ctl.go  <= 1'b1;
                        r_mul_ctl.opa <= r_acc ^ (in_block & keep_mask);
                        r_mul_ctl.opb <= r_key_p;
                        r_last        <= i_s_tlast;
                        r_len         <= in_len;
                        r_state       <= ST_MUL_P;
                    end
                end
                ST_MUL_P: begin
                    if (mul_stat.done) begin
                        if (r_last) begin
                            r_mul_ctl.go  <= 1'b1;
                            r_mul_ctl.opa <= mul_stat.product ^ {{(GF_W-LEN_W){1'b0}}, r_len};
                            r_mul_ctl.opb <= r_key_q;
                            r_state       <= ST_MUL_Q;
                        end else begin
                            r_acc   <= mul_stat.product;
                            r_state <= ST_IDLE;
                        end
                    end
                end
                ST_MUL_Q: begin
                    if (mul_stat.done) begin
                        r_hash  <= mul_stat.product;
                        r_state <= ST_EMIT;
                    end
                end
                ST_EMIT: begin
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_out_data  <= r_hash[GF_W-1 -: MAC_W] ^ r_mask;
                        r_acc       <= '0;
                        r_state     <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign o_s_tready = (r_state == ST_IDLE);
    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_fire |=> !o_s_tready)
        else $error("block took a new transaction while a block is in flight");

    a_go_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_mul_ctl.go |-> !mul_stat.busy)
        else $error("multiplier started while still busy");

    a_acc_clear_on_mac: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_m_tvalid) |-> (r_acc == '0))
        else $error("accumulator not cleared after mac");

endmodule

// ===== hw/rtl/uia2_gf_mul.sv =====
// digit-serial GF(2^64) multiplier, one 4-bit digit of the key per cycle
// depends on uia2_pkg

module uia2_gf_mul (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  uia2_pkg::t_mul_ctl  i_ctl,
    output uia2_pkg::t_mul_stat o_stat
);
    import uia2_pkg::*;

    logic [GF_W-1:0]   r_acc;
    logic [GF_W-1:0]   r_v;
    logic [GF_W-1:0]   r_k;
    logic [DCNT_W-1:0] r_cnt;
    logic              r_busy;
    logic              r_done;
    logic [GF_W-1:0]   n_acc;

    // horner step over key digits, most significant first
    assign n_acc = gf64_times_x4(r_acc) ^ gf64_times_digit(r_v, r_k[GF_W-1 -: DIGIT_W]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_ctl.go && !r_busy) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_acc  <= '0;
                r_v    <= i_ctl.opa;
                r_k    <= i_ctl.opb;
            end else if (r_busy) begin
                r_acc <= n_acc;
                r_k   <= {r_k[GF_W-DIGIT_W-1:0], {DIGIT_W{1'b0}}};
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == DCNT_W'(DIGITS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_stat.busy    = r_busy;
    assign o_stat.done    = r_done;
    assign o_stat.product = r_acc;

endmodule
